FILE: design/cicm_pkg.sv
// ----------------------------------------------------------------------------
// cicm_pkg: shared types and constants for the interval chain merge block
// Holds the payload structs, the buffer geometry and the command and status
// groups that join the controller and the datapath.
// ----------------------------------------------------------------------------
package cicm_pkg;

	// Buffer geometry and field widths.
	localparam int MAX_INTERVALS = 64;
	localparam int IDX_W         = $clog2(MAX_INTERVALS);
	localparam int CNT_W         = $clog2(MAX_INTERVALS + 1);
	localparam int COLOR_W       = 32;
	localparam int GAP_W         = 8;
	localparam logic [GAP_W-1:0] GAP_RESET = 8'd1;

	// Input transaction payload.
	typedef struct packed {
		logic [COLOR_W-1:0] interval_lo;
		logic [COLOR_W-1:0] interval_hi;
		logic               present;
		logic               last_item;
	} item_t;

	// Output transaction payload.
	typedef struct packed {
		logic [COLOR_W-1:0] merged_lo;
		logic [COLOR_W-1:0] merged_hi;
		logic               set_empty;
		logic               overflowed;
	} result_t;

	// One stored interval.
	typedef struct packed {
		logic [COLOR_W-1:0] lo;
		logic [COLOR_W-1:0] hi;
	} entry_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic latch;      // capture the accepted item, position := count
		logic ovf_set;    // the accepted interval is dropped, buffer full
		logic ins_rd;     // read the entry just below the insert position
		logic ins_shift;  // move the read entry up one place, position - 1
		logic ins_place;  // write the new interval at the position, count + 1
		logic sw_start;   // reset the position to the first entry
		logic sw_step;    // fold the read entry into the chain, position + 1
		logic finish;     // load the result register and start a new set
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic in_present;   // present bit of the offered item
		logic in_last;      // last bit of the offered item
		logic last_q;       // the item being inserted closes the set
		logic full;         // buffer holds MAX_INTERVALS entries
		logic pos_zero;     // insert position is at the bottom
		logic shift_needed; // read entry sorts after the new interval
		logic sweep_done;   // every stored entry has been folded in
		logic out_free;     // result register can take a new result
	} status_t;

endpackage

FILE: design/cicm_ctrl.sv
// ----------------------------------------------------------------------------
// cicm_ctrl: sequencing for insertion and the merge sweep
// Accepts one transaction at a time, steps the sorted insertion one entry at a
// time and, on a set's last item, sweeps the buffer before releasing the result.
// ----------------------------------------------------------------------------
module cicm_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              item_valid,
	output logic              item_stall,
	input  cicm_pkg::status_t status,
	output cicm_pkg::cmd_t    cmd
);
	import cicm_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_INS_CHK,
		ST_INS_CMP,
		ST_SW_RD,
		ST_SW_CMP,
		ST_FINISH
	} state_t;

	state_t state_q;
	state_t state_nx;

	// New transactions are taken only between sets of work.
	assign item_stall = (state_q != ST_IDLE);

	// Next state and commands.
	always_comb begin
		state_nx = state_q;
		cmd      = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (item_valid) begin
					cmd.latch = 1'b1;
					if (status.in_present && !status.full) begin
						state_nx = ST_INS_CHK;
					end else begin
						cmd.ovf_set = status.in_present;
						if (status.in_last) begin
							cmd.sw_start = 1'b1;
							state_nx     = ST_SW_RD;
						end
					end
				end
			end
			ST_INS_CHK: begin
				if (status.pos_zero) begin
					cmd.ins_place = 1'b1;
					cmd.sw_start  = status.last_q;
					state_nx      = status.last_q ? ST_SW_RD : ST_IDLE;
				end else begin
					cmd.ins_rd = 1'b1;
					state_nx   = ST_INS_CMP;
				end
			end
			ST_INS_CMP: begin
				if (status.shift_needed) begin
					cmd.ins_shift = 1'b1;
					state_nx      = ST_INS_CHK;
				end else begin
					cmd.ins_place = 1'b1;
					cmd.sw_start  = status.last_q;
					state_nx      = status.last_q ? ST_SW_RD : ST_IDLE;
				end
			end
			ST_SW_RD: begin
				state_nx = status.sweep_done ? ST_FINISH : ST_SW_CMP;
			end
			ST_SW_CMP: begin
				cmd.sw_step = 1'b1;
				state_nx    = ST_SW_RD;
			end
			ST_FINISH: begin
				if (status.out_free) begin
					cmd.finish = 1'b1;
					state_nx   = ST_IDLE;
				end
			end
			default: begin
				state_nx = ST_IDLE;
			end
		endcase
	end

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

endmodule

FILE: design/cicm_dp.sv
// ----------------------------------------------------------------------------
// cicm_dp: interval buffer, chain registers and result register
// Keeps the intervals sorted by lower color in a one-read, one-write memory,
// folds them into the running chain during the sweep and holds the result.
// ----------------------------------------------------------------------------
module cicm_dp (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_wr_en,
	input  logic [cicm_pkg::GAP_W-1:0]   cfg_wr_data,
	input  cicm_pkg::item_t              item_data,
	input  logic                         result_stall,
	output logic                         result_valid,
	output cicm_pkg::result_t            result_data,
	input  cicm_pkg::cmd_t               cmd,
	output cicm_pkg::status_t            status
);
	import cicm_pkg::*;

	entry_t            mem [MAX_INTERVALS];
	entry_t            rd_q;
	logic [IDX_W-1:0]  rd_addr;
	logic [IDX_W-1:0]  wr_addr;

	logic [GAP_W-1:0]   gap_q;
	logic [CNT_W-1:0]   count_q;
	logic [CNT_W-1:0]   pos_q;
	logic               ovf_q;
	logic               last_q;
	logic [COLOR_W-1:0] new_lo_q;
	logic [COLOR_W-1:0] new_hi_q;
	logic [COLOR_W-1:0] chain_lo_q;
	logic [COLOR_W-1:0] chain_hi_q;
	result_t            result_q;
	logic               result_valid_q;

	logic [COLOR_W-1:0] ov_start;
	logic [COLOR_W-1:0] ov_fin;
	logic [COLOR_W:0]   ov_reach;
	logic               touch;
	logic               set_empty;

	// Memory addressing: insertion reads one place below the write position.
	assign rd_addr = cmd.ins_rd ? IDX_W'(pos_q - 1'b1) : pos_q[IDX_W-1:0];
	assign wr_addr = pos_q[IDX_W-1:0];

	// Interval buffer with a registered read port.
	always_ff @(posedge clk) begin
		if (cmd.ins_shift) begin
			mem[wr_addr] <= rd_q;
		end else if (cmd.ins_place) begin
			mem[wr_addr] <= '{lo: new_lo_q, hi: new_hi_q};
		end
		rd_q <= mem[rd_addr];
	end

	// Overlap test: the smaller upper color plus the gap, one bit wider,
	// must reach the larger lower color.
	always_comb begin
		ov_start = (chain_lo_q > rd_q.lo) ? chain_lo_q : rd_q.lo;
		ov_fin   = (chain_hi_q < rd_q.hi) ? chain_hi_q : rd_q.hi;
		ov_reach = {1'b0, ov_fin} + (COLOR_W+1)'(gap_q);
		touch    = (ov_reach >= {1'b0, ov_start});
	end

	assign set_empty = (count_q == '0);

	// Control and chain registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gap_q          <= GAP_RESET;
			count_q        <= '0;
			pos_q          <= '0;
			ovf_q          <= 1'b0;
			last_q         <= 1'b0;
			result_valid_q <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				gap_q <= cfg_wr_data;
			end
			if (cmd.latch) begin
				last_q <= item_data.last_item;
			end
			priority if (cmd.sw_start) begin
				pos_q <= '0;
			end else if (cmd.ins_shift) begin
				pos_q <= pos_q - 1'b1;
			end else if (cmd.sw_step) begin
				pos_q <= pos_q + 1'b1;
			end else if (cmd.latch) begin
				pos_q <= count_q;
			end
			priority if (cmd.finish) begin
				count_q <= '0;
			end else if (cmd.ins_place) begin
				count_q <= count_q + 1'b1;
			end
			priority if (cmd.finish) begin
				ovf_q <= 1'b0;
			end else if (cmd.ovf_set) begin
				ovf_q <= 1'b1;
			end
			priority if (cmd.finish) begin
				result_valid_q <= 1'b1;
			end else if (!result_stall) begin
				result_valid_q <= 1'b0;
			end
		end
	end

	// Payload registers: the new interval, the running chain and the result.
	always_ff @(posedge clk) begin
		if (cmd.latch) begin
			new_lo_q <= item_data.interval_lo;
			new_hi_q <= item_data.interval_hi;
		end
		if (cmd.sw_step) begin
			if (pos_q == '0) begin
				chain_lo_q <= rd_q.lo;
				chain_hi_q <= rd_q.hi;
			end else if (touch) begin
				if (rd_q.lo < chain_lo_q) begin
					chain_lo_q <= rd_q.lo;
				end
				if (rd_q.hi > chain_hi_q) begin
					chain_hi_q <= rd_q.hi;
				end
			end
		end
		if (cmd.finish) begin
			result_q.merged_lo  <= set_empty ? '0 : chain_lo_q;
			result_q.merged_hi  <= set_empty ? '0 : chain_hi_q;
			result_q.set_empty  <= set_empty;
			result_q.overflowed <= ovf_q;
		end
	end

	assign result_valid = result_valid_q;
	assign result_data  = result_q;

	// Status back to the controller.
	always_comb begin
		status.in_present   = item_data.present;
		status.in_last      = item_data.last_item;
		status.last_q       = last_q;
		status.full         = (count_q == CNT_W'(MAX_INTERVALS));
		status.pos_zero     = (pos_q == '0);
		status.shift_needed = (rd_q.lo > new_lo_q);
		status.sweep_done   = (pos_q == count_q);
		status.out_free     = !result_valid_q || !result_stall;
	end

	// The fill count never passes the buffer depth.
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(MAX_INTERVALS))
		else $error("interval count beyond buffer depth");

	// Shifting an entry up needs an entry below the insert position.
	a_shift_pos: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.ins_shift |-> (pos_q != '0))
		else $error("shift requested at bottom of buffer");

	// Placing an interval grows the buffer by exactly one.
	a_place_count: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.ins_place |=> (count_q == $past(count_q) + 1'b1))
		else $error("insert did not advance the count");

	// A finished set leaves a valid result and an empty, clean buffer.
	a_finish: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.finish |=> (result_valid_q && (count_q == '0) && !ovf_q))
		else $error("set not closed after result load");

	// A result is only loaded when the previous one is gone or leaving.
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.finish |-> (!result_valid_q || !result_stall))
		else $error("result register overwritten");

endmodule

FILE: design/color_interval_chain_merge.sv
// ----------------------------------------------------------------------------
// color_interval_chain_merge: sorted interval collection with a merge sweep
// Top level joining the sequencing controller and the interval datapath.
// ----------------------------------------------------------------------------
// One transaction is taken at a time. An item without an interval, or one that
// is dropped because the 64-entry buffer is full, is not stored. An interval
// is inserted by moving each larger entry up one place, read then written,
// through the one-read, one-write buffer memory, then placed below them.
// An item marked last adds the sweep, which reads and folds each stored
// interval in turn, before the result transaction is offered; the result
// load waits only if the previous result is still held. The buffer needs no
// clearing after reset. merge_gap is written through cfg_wr_en and
// cfg_wr_data; the user must do so only while idle, the block does not check.
module color_interval_chain_merge (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_wr_en,
	input  logic [cicm_pkg::GAP_W-1:0] cfg_wr_data,
	input  logic                       item_valid,
	output logic                       item_stall,
	input  cicm_pkg::item_t            item_data,
	output logic                       result_valid,
	input  logic                       result_stall,
	output cicm_pkg::result_t          result_data
);
	import cicm_pkg::*;

	cmd_t    cmd;
	status_t status;

	// Sequencing.
	cicm_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_stall (item_stall),
		.status     (status),
		.cmd        (cmd)
	);

	// Buffer, chain and result.
	cicm_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_wr_en    (cfg_wr_en),
		.cfg_wr_data  (cfg_wr_data),
		.item_data    (item_data),
		.result_stall (result_stall),
		.result_valid (result_valid),
		.result_data  (result_data),
		.cmd          (cmd),
		.status       (status)
	);

endmodule

FILE: verif/tb_color_interval_chain_merge.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_color_interval_chain_merge: self-checking bench for the interval merger
// Sets of intervals go in through a queue-fed driver, and an in-bench
// predictor sorts them and runs the merge sweep. A monitor compares every
// merged result with the oldest prediction. Both sides idle at random, and
// merge_gap is rewritten between phases.
// ----------------------------------------------------------------------------
module tb_color_interval_chain_merge;
	import cicm_pkg::*;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  cfg_wr_en = 1'b0;
	logic [GAP_W-1:0]      cfg_wr_data = '0;
	logic                  item_valid = 1'b0;
	logic                  item_stall;
	item_t                 item_data = '0;
	logic                  result_valid;
	logic                  result_stall = 1'b0;
	result_t               result_data;

	// Stimulus and expectation stores.
	item_t                 items_to_send[$];
	result_t               merged_due[$];
	int                    phase_items = 0;
	int                    mismatch_count = 0;

	// Random idling controls: zero odds means no idling at all.
	int                    idle_odds = 0;
	int                    tx_gap = 0;
	int                    rx_burst = 0;
	int                    rx_hold_left = 0;
	logic                  item_taken = 1'b0;

	// Predictor state: the sorted interval buffer and its bookkeeping.
	logic [COLOR_W-1:0]    held_lo [MAX_INTERVALS];
	logic [COLOR_W-1:0]    held_hi [MAX_INTERVALS];
	int                    held_count = 0;
	logic                  held_dropped = 1'b0;
	logic [GAP_W-1:0]      gap_setting = GAP_RESET;

	color_interval_chain_merge dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_wr_en    (cfg_wr_en),
		.cfg_wr_data  (cfg_wr_data),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.item_data    (item_data),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result_data  (result_data)
	);

	// Clock generation.
	initial begin
		forever #1 clk = ~clk;
	end

	// Insert one accepted item into the sorted buffer and, when it closes the
	// set, sweep the buffer and queue the merged interval it should produce.
	function automatic void absorb_item(input item_t it);
		int                 pos;
		int                 k;
		logic [COLOR_W-1:0] run_lo;
		logic [COLOR_W-1:0] run_hi;
		logic [COLOR_W-1:0] far_lo;
		logic [COLOR_W-1:0] near_hi;
		logic [COLOR_W:0]   reach;
		result_t            r;
		if (it.present) begin
			if (held_count >= MAX_INTERVALS) begin
				held_dropped = 1'b1;
			end else begin
				// Equal lower colors keep their arrival order.
				pos = held_count;
				while (pos > 0 && held_lo[pos-1] > it.interval_lo)
					pos--;
				for (k = held_count; k > pos; k--) begin
					held_lo[k] = held_lo[k-1];
					held_hi[k] = held_hi[k-1];
				end
				held_lo[pos] = it.interval_lo;
				held_hi[pos] = it.interval_hi;
				held_count++;
			end
		end
		if (it.last_item) begin
			run_lo = '0;
			run_hi = '0;
			if (held_count > 0) begin
				run_lo = held_lo[0];
				run_hi = held_hi[0];
				for (k = 1; k < held_count; k++) begin
					far_lo  = (run_lo > held_lo[k]) ? run_lo : held_lo[k];
					near_hi = (run_hi < held_hi[k]) ? run_hi : held_hi[k];
					// The reach is one bit wider so it never wraps.
					reach = {1'b0, near_hi} + gap_setting;
					if (reach >= {1'b0, far_lo}) begin
						if (held_lo[k] < run_lo)
							run_lo = held_lo[k];
						if (held_hi[k] > run_hi)
							run_hi = held_hi[k];
					end
				end
			end
			r.merged_lo  = run_lo;
			r.merged_hi  = run_hi;
			r.set_empty  = (held_count == 0);
			r.overflowed = held_dropped;
			merged_due.push_back(r);
			held_count   = 0;
			held_dropped = 1'b0;
		end
	endfunction

	function automatic void check_field(input string name, input logic [COLOR_W-1:0] want,
			input logic [COLOR_W-1:0] got);
		if (got !== want) begin
			$error("%s: expected %0h, got %0h", name, want, got);
			mismatch_count++;
		end
	endfunction

	// Item driver: holds a stalled transaction, otherwise idles at random or
	// offers the next pending item.
	always @(negedge clk) begin
		logic  nv;
		item_t nd;
		nv = 1'b0;
		nd = item_data;
		if (arst_n) begin
			if (item_valid && !item_taken) begin
				nv = 1'b1;
			end else if (tx_gap > 0) begin
				tx_gap--;
			end else if (items_to_send.size() > 0) begin
				if (idle_odds != 0 && $urandom_range(1, idle_odds) == 1) begin
					tx_gap = $urandom_range(0, 2);
				end else begin
					nv = 1'b1;
					nd = items_to_send[0];
				end
			end
		end
		item_taken = 1'b0;
		item_valid <= nv;
		item_data  <= nd;
	end

	// Result receiver: a requested long hold first, then short random stalls.
	always @(negedge clk) begin
		logic ns;
		ns = 1'b0;
		if (rx_hold_left > 0) begin
			rx_hold_left--;
			ns = 1'b1;
		end else if (rx_burst > 0) begin
			rx_burst--;
			ns = 1'b1;
		end else if (idle_odds != 0 && $urandom_range(1, idle_odds) == 1) begin
			rx_burst = $urandom_range(0, 2);
			ns = 1'b1;
		end
		result_stall <= ns;
	end

	// Monitor: predicts on each accepted item and checks each accepted result.
	always @(posedge clk) begin
		result_t due;
		if (arst_n) begin
			if (item_valid && !item_stall) begin
				absorb_item(item_data);
				void'(items_to_send.pop_front());
				item_taken = 1'b1;
			end
			if (result_valid && !result_stall) begin
				if (merged_due.size() == 0) begin
					$error("result transaction with no expectation: lo %0h hi %0h",
						result_data.merged_lo, result_data.merged_hi);
					mismatch_count++;
				end else begin
					due = merged_due.pop_front();
					check_field("merged_lo", due.merged_lo, result_data.merged_lo);
					check_field("merged_hi", due.merged_hi, result_data.merged_hi);
					check_field("set_empty", COLOR_W'(due.set_empty),
						COLOR_W'(result_data.set_empty));
					check_field("overflowed", COLOR_W'(due.overflowed),
						COLOR_W'(result_data.overflowed));
				end
			end
		end
	end

	task automatic queue_item(input logic [COLOR_W-1:0] lo, input logic [COLOR_W-1:0] hi,
			input logic present, input logic last);
		item_t it;
		it.interval_lo = lo;
		it.interval_hi = hi;
		it.present     = present;
		it.last_item   = last;
		items_to_send.push_back(it);
		phase_items++;
	endtask

	// One set of n intervals. Style 0 clusters them so that merging depends
	// on the gap, style 1 spreads them over the whole range, and style 2
	// packs them against the top of the color range.
	task automatic queue_set(input int n, input int style);
		logic [COLOR_W-1:0] base;
		logic [COLOR_W-1:0] lo;
		logic [COLOR_W-1:0] hi;
		logic [COLOR_W-1:0] prev_lo;
		logic [COLOR_W-1:0] t;
		logic               bare_end;
		int                 i;
		base     = (style == 2) ? 32'hFFFF_FFFF - $urandom_range(0, 1200) : $urandom;
		bare_end = (n == 0) || ($urandom_range(0, 4) == 0);
		prev_lo  = base;
		for (i = 0; i < n; i++) begin
			// Occasional items without an interval in the middle of the set.
			if ($urandom_range(0, 9) == 0)
				queue_item($urandom, $urandom, 1'b0, 1'b0);
			if (style == 1) begin
				lo = $urandom;
				hi = $urandom;
			end else begin
				lo = ($urandom_range(0, 7) == 0) ? prev_lo : base + $urandom_range(0, 600);
				hi = lo + $urandom_range(0, 300);
				if ($urandom_range(0, 15) == 0) begin
					t  = lo;
					lo = hi;
					hi = t;
				end
			end
			prev_lo = lo;
			queue_item(lo, hi, 1'b1, (i == n - 1) && !bare_end);
		end
		if (bare_end)
			queue_item($urandom, $urandom, 1'b0, 1'b1);
	endtask

	// Random sets until about target items have been queued; most are small.
	task automatic queue_random_sets(input int target);
		int start;
		int r;
		int n;
		int style;
		start = phase_items;
		while (phase_items - start < target) begin
			r = $urandom_range(0, 99);
			if (r < 8)
				n = 0;
			else if (r < 85)
				n = $urandom_range(1, 8);
			else
				n = $urandom_range(9, 30);
			r = $urandom_range(0, 99);
			style = (r < 60) ? 0 : (r < 85) ? 1 : 2;
			queue_set(n, style);
		end
	endtask

	task automatic write_gap(input logic [GAP_W-1:0] v);
		@(negedge clk);
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= v;
		@(negedge clk);
		cfg_wr_en   <= 1'b0;
		gap_setting = v;
	endtask

	// Wait until every item is taken and every result has come, then let the
	// longest insertion and sweep time pass.
	task automatic wait_drained();
		while (items_to_send.size() != 0 || merged_due.size() != 0)
			@(posedge clk);
		repeat (300) @(posedge clk);
	endtask

	// Main sequence: reset, a directed phase, then random phases at several
	// gap settings.
	initial begin
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// Directed sets at the reset gap of one.
		idle_odds = 5;
		// Empty set closed by a bare end marker.
		queue_item(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, 1'b1);
		// Single interval at the very top of the range.
		queue_item(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 1'b1);
		// Two extremes that do not touch.
		queue_item(32'h0000_0000, 32'h0000_0000, 1'b1, 1'b0);
		queue_item(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 1'b1);
		// Arrival in falling order; only the consecutive pair merges.
		queue_item(32'd35, 32'd40, 1'b1, 1'b0);
		queue_item(32'd21, 32'd30, 1'b1, 1'b0);
		queue_item(32'd10, 32'd20, 1'b1, 1'b1);
		// A reversed interval followed by ordinary ones and a bare item.
		queue_item(32'd100, 32'd50, 1'b1, 1'b0);
		queue_item(32'd60, 32'd70, 1'b1, 1'b0);
		queue_item(32'h5555_5555, 32'hAAAA_AAAA, 1'b0, 1'b0);
		queue_item(32'd60, 32'd80, 1'b1, 1'b1);
		// The reach past the top color must not wrap.
		queue_item(32'hFFFF_FF00, 32'hFFFF_FFFE, 1'b1, 1'b0);
		queue_item(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 1'b0);
		queue_item(32'hFFFF_FF80, 32'hFFFF_FF90, 1'b1, 1'b1);
		// Equal lower colors, closed by a bare end marker.
		queue_item(32'd5, 32'd9, 1'b1, 1'b0);
		queue_item(32'd5, 32'd7, 1'b1, 1'b0);
		queue_item(32'd12, 32'd14, 1'b0, 1'b1);
		wait_drained();

		// Zero gap, with a long receiver hold so that the input backs up.
		write_gap(8'd0);
		@(posedge clk);
		rx_hold_left = 400;
		idle_odds    = 4;
		queue_random_sets(130);
		wait_drained();

		// Widest gap: a full buffer, then one that overflows.
		write_gap(8'd255);
		idle_odds = 6;
		queue_set(MAX_INTERVALS, 0);
		queue_set(MAX_INTERVALS + 2, 0);
		queue_random_sets(70);
		wait_drained();

		// Random gap, with an overflow whose closing interval is dropped.
		write_gap(GAP_W'($urandom_range(0, 255)));
		idle_odds = 3;
		queue_set(MAX_INTERVALS + 1, 1);
		queue_random_sets(90);
		wait_drained();

		// Final stretch without any idling.
		write_gap(8'd1);
		idle_odds = 0;
		queue_random_sets(130);
		wait_drained();

		if (mismatch_count == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

	// Run time limit.
	initial begin
		#2_000_000;
		$display("CHECKS FAILED");
		$finish;
	end

endmodule
